// ===== design/slp_pkg.sv =====
`default_nettype none
package slp_pkg;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ZERO = 4'b0010,
    PH_DEC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_t;

  // Status codes of a result.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NODIGIT  = 3'd1;
  localparam logic [2:0] ST_TOOLARGE = 3'd2;
  localparam logic [2:0] ST_HALFWORD = 3'd3;
  localparam logic [2:0] ST_HEXLEN   = 3'd4;

  // Size codes of a result.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Character constants.
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_H = 8'h48;
  localparam logic [7:0] CH_UPPER_W = 8'h57;

  // Value limits.
  localparam logic [35:0] LIMIT32   = 36'h0_FFFF_FFFF;
  localparam logic [31:0] HALF_MIN  = 32'h0001_0000;
  localparam logic [31:0] BYTE2_MIN = 32'h0000_0100;
  localparam logic [3:0]  HEX_CNT_MAX = 4'd15;

  // Decoded view of one character.
  typedef struct packed {
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] digit;
    logic       is_x;
    logic       is_h;
    logic       is_w;
  } char_info_t;

  // One result of the parser.
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  size_code;
    logic [2:0]  status;
    logic        end_consumed;
  } result_t;

endpackage
`default_nettype wire

// ===== design/sized_integer_literal_parser.sv =====
`default_nettype none
// Sized integer literal parser. Feed one ASCII character per request on the
// in_ channel; each character that ends a literal (decimal with an optional H
// or W suffix, or 0x hex) yields one request on the out_ channel carrying the
// value, byte size, status and whether the suffix was consumed. The block
// takes one character every cycle while the input is not stalled. A result
// is presented once its terminating character has sat in the input register,
// where the state update is worked out, and the outcome has been captured in
// the result register, which waits while an earlier result is still held.
// A waiting result stalls the input only when the next character also ends a
// literal; digits keep flowing while a result is held.
module sized_integer_literal_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_value,
  output logic [1:0]       out_size_code,
  output logic [2:0]       out_status,
  output logic             out_end_consumed
);

  logic                in_vld_r;
  logic [7:0]          in_ch_r;
  logic                out_vld_r;
  slp_pkg::result_t    out_res_r;
  slp_pkg::char_info_t info;
  slp_pkg::result_t    result;
  logic                emit;
  logic                advance;

  slp_char_decode u_decode (
    .ch   (in_ch_r),
    .info (info)
  );

  slp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .info   (info),
    .emit   (emit),
    .result (result)
  );

  // The held character moves on unless it has a result with nowhere to go.
  assign advance  = in_vld_r && (!emit || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_ch_r <= in_ch;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res_r <= result;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_value        = out_res_r.value;
  assign out_size_code    = out_res_r.size_code;
  assign out_status       = out_res_r.status;
  assign out_end_consumed = out_res_r.end_consumed;

endmodule
`default_nettype wire

// ===== design/slp_char_decode.sv =====
`default_nettype none
module slp_char_decode (
  input  wire logic [7:0]        ch,
  output slp_pkg::char_info_t    info
);

  // Classify the character and extract its digit value.
  always_comb begin
    info        = '0;
    info.is_x   = (ch == slp_pkg::CH_LOWER_X);
    info.is_h   = (ch == slp_pkg::CH_UPPER_H);
    info.is_w   = (ch == slp_pkg::CH_UPPER_W);
    if (ch inside {[8'h30:8'h39]}) begin
      info.dec_ok = 1'b1;
      info.hex_ok = 1'b1;
      info.digit  = 4'(ch - 8'h30);
    end else if (ch inside {[8'h41:8'h46]}) begin
      info.hex_ok = 1'b1;
      info.digit  = 4'(ch - 8'h37);
    end else if (ch inside {[8'h61:8'h66]}) begin
      info.hex_ok = 1'b1;
      info.digit  = 4'(ch - 8'h57);
    end
  end

endmodule
`default_nettype wire

// ===== design/slp_core.sv =====
`default_nettype none
module slp_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire slp_pkg::char_info_t  info,
  output logic                      emit,
  output slp_pkg::result_t          result
);

  slp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]     accum_r, accum_nxt;
  logic            ovf_r, ovf_nxt;
  logic [3:0]      hex_cnt_r, hex_cnt_nxt;

  logic [35:0] dec_sum;
  logic [35:0] hex_sum;

  // Constant-multiply accumulate for both radixes.
  assign dec_sum = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + {32'b0, info.digit};
  assign hex_sum = ({4'b0, accum_r} << 4) + {32'b0, info.digit};

  // Next state and result for the current character.
  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    ovf_nxt     = ovf_r;
    hex_cnt_nxt = hex_cnt_r;
    emit        = 1'b0;
    result      = '0;
    case (phase_r)
      slp_pkg::PH_IDLE: begin
        if (!info.dec_ok) begin
          emit          = 1'b1;
          result.status = slp_pkg::ST_NODIGIT;
        end else begin
          accum_nxt   = {28'b0, info.digit};
          ovf_nxt     = 1'b0;
          hex_cnt_nxt = '0;
          phase_nxt   = (info.digit == 4'd0) ? slp_pkg::PH_ZERO : slp_pkg::PH_DEC;
        end
      end
      slp_pkg::PH_ZERO, slp_pkg::PH_DEC: begin
        if (phase_r == slp_pkg::PH_ZERO && info.is_x) begin
          phase_nxt   = slp_pkg::PH_HEX;
          accum_nxt   = '0;
          hex_cnt_nxt = '0;
        end else if (info.dec_ok) begin
          phase_nxt = slp_pkg::PH_DEC;
          if (!ovf_r) begin
            if (dec_sum >= slp_pkg::LIMIT32) begin
              ovf_nxt = 1'b1;
            end else begin
              accum_nxt = dec_sum[31:0];
            end
          end
        end else begin
          emit = 1'b1;
          if (ovf_r) begin
            result.status = slp_pkg::ST_TOOLARGE;
          end else if (info.is_h) begin
            if (accum_r >= slp_pkg::HALF_MIN) begin
              result.status = slp_pkg::ST_HALFWORD;
            end else begin
              result.value        = accum_r;
              result.size_code    = slp_pkg::SZ_HALF;
              result.end_consumed = 1'b1;
            end
          end else if (info.is_w) begin
            result.value        = accum_r;
            result.size_code    = slp_pkg::SZ_WORD;
            result.end_consumed = 1'b1;
          end else begin
            result.value = accum_r;
            if (accum_r >= slp_pkg::HALF_MIN) begin
              result.size_code = slp_pkg::SZ_WORD;
            end else if (accum_r >= slp_pkg::BYTE2_MIN) begin
              result.size_code = slp_pkg::SZ_HALF;
            end else begin
              result.size_code = slp_pkg::SZ_BYTE;
            end
          end
        end
      end
      slp_pkg::PH_HEX: begin
        if (info.hex_ok) begin
          if (!ovf_r) begin
            if (hex_sum >= slp_pkg::LIMIT32) begin
              ovf_nxt = 1'b1;
            end else begin
              accum_nxt = hex_sum[31:0];
            end
          end
          if (hex_cnt_r < slp_pkg::HEX_CNT_MAX) begin
            hex_cnt_nxt = hex_cnt_r + 4'd1;
          end
        end else begin
          emit = 1'b1;
          if (ovf_r) begin
            result.status = slp_pkg::ST_TOOLARGE;
          end else begin
            case (hex_cnt_r)
              4'd2: begin
                result.value     = accum_r;
                result.size_code = slp_pkg::SZ_BYTE;
              end
              4'd4: begin
                result.value     = accum_r;
                result.size_code = slp_pkg::SZ_HALF;
              end
              4'd8: begin
                result.value     = accum_r;
                result.size_code = slp_pkg::SZ_WORD;
              end
              default: begin
                result.status = slp_pkg::ST_HEXLEN;
              end
            endcase
          end
        end
      end
      default: begin
        phase_nxt = slp_pkg::PH_IDLE;
      end
    endcase
    // Every result ends the literal and returns the parser to idle.
    if (emit) begin
      phase_nxt   = slp_pkg::PH_IDLE;
      accum_nxt   = '0;
      ovf_nxt     = 1'b0;
      hex_cnt_nxt = '0;
    end
  end

  // Parser state, updated once per consumed character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= slp_pkg::PH_IDLE;
      accum_r   <= '0;
      ovf_r     <= 1'b0;
      hex_cnt_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      accum_r   <= accum_nxt;
      ovf_r     <= ovf_nxt;
      hex_cnt_r <= hex_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_sized_integer_literal_parser.sv =====
module tb_sized_integer_literal_parser;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value;
  logic [1:0]  out_size_code;
  logic [2:0]  out_status;
  logic        out_end_consumed;

  // Idle rates of both sides, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-off: the test asks, the receiver process counts it out.
  int hold_asked = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  int chars_sent = 0;
  int mismatches = 0;

  // Predicted parser state.
  slp_pkg::phase_t lit_phase  = slp_pkg::PH_IDLE;
  logic [31:0]     lit_acc    = '0;
  bit              lit_big    = 1'b0;
  logic [3:0]      lit_hexcnt = '0;

  // Literal results predicted but not yet seen on the result channel.
  slp_pkg::result_t pending_results[$];

  sized_integer_literal_parser uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_size_code    (out_size_code),
    .out_status       (out_status),
    .out_end_consumed (out_end_consumed)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Digit decoders; they return -1 for a character outside the radix.
  function automatic int dec_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    return -1;
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  // Queue one result and return the parser to idle.
  function automatic void finish_literal(logic [31:0] v, logic [1:0] sz, logic [2:0] st,
                                         logic ec);
    slp_pkg::result_t r;
    r.value        = v;
    r.size_code    = sz;
    r.status       = st;
    r.end_consumed = ec;
    pending_results = {pending_results, r};
    lit_phase  = slp_pkg::PH_IDLE;
    lit_acc    = '0;
    lit_big    = 1'b0;
    lit_hexcnt = '0;
  endfunction

  // Multiply-add one digit; the accumulator freezes once a sum would reach all ones.
  function automatic void add_digit(int radix, int d);
    logic [63:0] n;
    if (lit_big) return;
    n = 64'(lit_acc) * 64'(radix) + 64'(d);
    if (n >= slp_pkg::LIMIT32) lit_big = 1'b1;
    else lit_acc = n[31:0];
  endfunction

  // Advance the predicted parser by one accepted character.
  function automatic void parse_char(logic [7:0] c);
    int d;
    if (lit_phase == slp_pkg::PH_IDLE) begin
      d = dec_val(c);
      if (d < 0) begin
        finish_literal('0, slp_pkg::SZ_BYTE, slp_pkg::ST_NODIGIT, 1'b0);
        return;
      end
      lit_acc    = 32'(d);
      lit_big    = 1'b0;
      lit_hexcnt = '0;
      lit_phase  = (d == 0) ? slp_pkg::PH_ZERO : slp_pkg::PH_DEC;
      return;
    end
    // A lowercase x right after a leading zero switches to hex.
    if (lit_phase == slp_pkg::PH_ZERO && c == slp_pkg::CH_LOWER_X) begin
      lit_phase  = slp_pkg::PH_HEX;
      lit_acc    = '0;
      lit_hexcnt = '0;
      return;
    end
    if (lit_phase == slp_pkg::PH_HEX) begin
      d = hex_val(c);
      if (d >= 0) begin
        add_digit(16, d);
        if (lit_hexcnt != slp_pkg::HEX_CNT_MAX) lit_hexcnt++;
        return;
      end
      if (lit_big)
        finish_literal('0, slp_pkg::SZ_BYTE, slp_pkg::ST_TOOLARGE, 1'b0);
      else if (lit_hexcnt == 4'd2)
        finish_literal(lit_acc, slp_pkg::SZ_BYTE, slp_pkg::ST_OK, 1'b0);
      else if (lit_hexcnt == 4'd4)
        finish_literal(lit_acc, slp_pkg::SZ_HALF, slp_pkg::ST_OK, 1'b0);
      else if (lit_hexcnt == 4'd8)
        finish_literal(lit_acc, slp_pkg::SZ_WORD, slp_pkg::ST_OK, 1'b0);
      else
        finish_literal('0, slp_pkg::SZ_BYTE, slp_pkg::ST_HEXLEN, 1'b0);
      return;
    end
    // Decimal, including a leading zero that was not followed by x.
    d = dec_val(c);
    if (d >= 0) begin
      lit_phase = slp_pkg::PH_DEC;
      add_digit(10, d);
      return;
    end
    if (lit_big)
      finish_literal('0, slp_pkg::SZ_BYTE, slp_pkg::ST_TOOLARGE, 1'b0);
    else if (c == slp_pkg::CH_UPPER_H) begin
      if (lit_acc >= slp_pkg::HALF_MIN)
        finish_literal('0, slp_pkg::SZ_BYTE, slp_pkg::ST_HALFWORD, 1'b0);
      else
        finish_literal(lit_acc, slp_pkg::SZ_HALF, slp_pkg::ST_OK, 1'b1);
    end else if (c == slp_pkg::CH_UPPER_W)
      finish_literal(lit_acc, slp_pkg::SZ_WORD, slp_pkg::ST_OK, 1'b1);
    else if (lit_acc >= slp_pkg::HALF_MIN)
      finish_literal(lit_acc, slp_pkg::SZ_WORD, slp_pkg::ST_OK, 1'b0);
    else if (lit_acc >= slp_pkg::BYTE2_MIN)
      finish_literal(lit_acc, slp_pkg::SZ_HALF, slp_pkg::ST_OK, 1'b0);
    else
      finish_literal(lit_acc, slp_pkg::SZ_BYTE, slp_pkg::ST_OK, 1'b0);
  endfunction

  // Offer one character, starting and ending at a falling edge.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  // Stop offering and let every predicted result come out.
  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // A character that ends a literal of the given radix, suffixes often.
  function automatic logic [7:0] pick_terminator(bit hex_radix);
    logic [7:0] c;
    case ($urandom_range(5))
      0: return slp_pkg::CH_UPPER_H;
      1: return slp_pkg::CH_UPPER_W;
      default: begin
        do c = 8'($urandom_range(255));
        while (hex_radix ? hex_val(c) >= 0 : dec_val(c) >= 0);
        return c;
      end
    endcase
  endfunction

  // One random literal: mostly well formed, some noise and broken prefixes.
  task automatic send_random_literal;
    int          kind;
    int          n;
    logic [31:0] v;
    string       digits;
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_char(8'($urandom_range(255)));
    end else if (kind < 55) begin
      case ($urandom_range(5))
        0: v = $urandom_range(9);
        1: v = $urandom_range(999);
        2: v = $urandom_range(70000);
        3: v = $urandom;
        4: begin
          case ($urandom_range(5))
            0: v = 32'd255;
            1: v = 32'd256;
            2: v = 32'd65535;
            3: v = 32'd65536;
            4: v = 32'hFFFF_FFFE;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
        default: v = $urandom_range(300);
      endcase
      digits = $sformatf("%0d", v);
      // An extra digit pushes large values past 32 bits.
      if ($urandom_range(7) == 0) digits = {digits, "9"};
      if ($urandom_range(7) == 0) digits = {"0", digits};
      send_text(digits);
      send_char(pick_terminator(1'b0));
    end else begin
      case ($urandom_range(9))
        0, 1: n = 2;
        2, 3: n = 4;
        4, 5, 6: n = 8;
        default: n = $urandom_range(12);
      endcase
      if (n == 8 && $urandom_range(3) == 0) begin
        if ($urandom_range(1) != 0) digits = "ffffffff";
        else digits = "fffffffe";
      end else begin
        digits = "";
        for (int i = 0; i < n; i++)
          digits = $sformatf("%s%h", digits, 4'($urandom_range(15)));
      end
      for (int i = 0; i < digits.len(); i++)
        if (digits[i] >= "a" && $urandom_range(1) != 0) digits.putc(i, digits[i] - 8'h20);
      case ($urandom_range(19))
        0: send_text("0X");
        1: send_text("00x");
        default: send_text("0x");
      endcase
      send_text(digits);
      send_char(pick_terminator(1'b1));
    end
  endtask

  // Character extremes and several special cases of the grammar.
  task automatic test_directed_cases;
    send_char(8'h00);
    send_char(8'hFF);
    send_text("0X");
    send_text("0x ");
    send_text("0xfFg");
    send_text("7H");
    send_text("9W");
    send_text("05,");
    send_text("70000H");
  endtask

  task automatic test_random_literals(input int count);
    int stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) send_random_literal();
  endtask

  // Hold the result channel off while short literals keep arriving.
  task automatic test_output_backpressure;
    wait_for_results();
    set_idling(0, 0);
    hold_asked++;
    repeat (20) send_text("1,");
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Compare each accepted result request with the oldest prediction.
  always @(posedge clk) begin : check_results
    slp_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0h status %0d",
                 $time, out_value, out_status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("value", want.value, out_value);
        check_field("size_code", 32'(want.size_code), 32'(out_size_code));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("end_consumed", 32'(want.end_consumed), 32'(out_end_consumed));
      end
    end
  end

  // End the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(25, 74);
    test_directed_cases();
    test_random_literals(112);
    set_idling(74, 25);
    test_random_literals(112);
    set_idling(0, 0);
    test_random_literals(111);
    test_output_backpressure();
    wait_for_results();

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
